FILE: rtl/sdets_pkg.sv
// ----------------------------------------------------------------------------
// sdets_pkg
// Shared types, codes and character constants for the script end-tag scanner.
// ----------------------------------------------------------------------------
package sdets_pkg;

  localparam int POSITION_BITS_DEFAULT = 32;
  localparam int NAME_POS_BITS         = 32;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [2:0] NAME_LEN = 3'd6;
  localparam logic [2:0] NAME_SAT = 3'd7;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SPACE = 2'd1,
    EV_SLASH = 2'd2,
    EV_GT    = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    MODE_DATA    = 2'd0,
    MODE_ESCAPED = 2'd1,
    MODE_DOUBLE  = 2'd2,
    MODE_ENDED   = 2'd3
  } mode_t;

  typedef enum logic [18:0] {
    ST_DATA         = 19'h00001,
    ST_LT           = 19'h00002,
    ST_END_OPEN     = 19'h00004,
    ST_END_NAME     = 19'h00008,
    ST_ESC_START    = 19'h00010,
    ST_ESC_START_D  = 19'h00020,
    ST_ESC          = 19'h00040,
    ST_ESC_D        = 19'h00080,
    ST_ESC_DD       = 19'h00100,
    ST_ESC_LT       = 19'h00200,
    ST_ESC_END_OPEN = 19'h00400,
    ST_ESC_END_NAME = 19'h00800,
    ST_DBL_START    = 19'h01000,
    ST_DBL          = 19'h02000,
    ST_DBL_D        = 19'h04000,
    ST_DBL_DD       = 19'h08000,
    ST_DBL_LT       = 19'h10000,
    ST_DBL_END      = 19'h20000,
    ST_ENDED        = 19'h40000
  } scan_state_t;

  // lower-case "script", by letter index
  function automatic logic [7:0] script_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h63;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h70;
      3'd5:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic mode_t mode_of(scan_state_t s);
    mode_t m;
    unique case (s)
      ST_ENDED: m = MODE_ENDED;
      ST_DBL, ST_DBL_D, ST_DBL_DD, ST_DBL_LT, ST_DBL_END: m = MODE_DOUBLE;
      ST_ESC, ST_ESC_D, ST_ESC_DD, ST_ESC_LT, ST_ESC_END_OPEN, ST_ESC_END_NAME,
      ST_DBL_START: m = MODE_ESCAPED;
      default: m = MODE_DATA;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/script_data_end_tag_scanner_top.sv
// ----------------------------------------------------------------------------
// script_data_end_tag_scanner_top
// Result: registered; the result beat appears in the cycle after the input beat is accepted.
// Throughput: one byte per cycle while out_ready is high; the per-byte update
//   (up to four tokenizer state passes) settles between scan state registers.
// Reset: synchronous active-high rst returns to script data, position zero,
//   output register empty.
// ----------------------------------------------------------------------------
// Walks the script-data / escaped / double-escaped tokenizer states and
// reports a closing script end tag with its terminator and name position.
// ----------------------------------------------------------------------------
module script_data_end_tag_scanner_top
  import sdets_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               data_byte,
  input  logic                     begin_script,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               event_res,
  output logic [NAME_POS_BITS-1:0] name_position,
  output logic [1:0]               script_mode
);

  localparam int PASSES = 4;

  typedef struct packed {
    scan_state_t              state;
    logic [2:0]               count;
    logic                     match;
    logic [POSITION_BITS-1:0] start;
  } scan_t;

  typedef struct packed {
    scan_t  s;
    logic   again;
    event_t ev;
  } pass_t;

  scan_t                    scan;
  scan_t                    scan_next;
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] byte_position_next;
  event_t                   ev_next;
  logic                     in_fire;

  function automatic scan_t name_add(scan_t s, logic [7:0] b);
    scan_t r;
    r = s;
    if (s.count >= NAME_LEN || (b | CH_CASE) != script_char(s.count)) begin
      r.match = 1'b0;
    end
    if (s.count < NAME_SAT) begin
      r.count = s.count + 3'd1;
    end
    return r;
  endfunction

  function automatic pass_t scan_pass(scan_t s, logic [7:0] b,
                                      logic [POSITION_BITS-1:0] pos);
    pass_t  r;
    event_t term;
    logic   alpha;
    logic   is_script;
    r.s       = s;
    r.again   = 1'b0;
    r.ev      = EV_NONE;
    alpha     = ((b | CH_CASE) >= CH_LO_A) && ((b | CH_CASE) <= CH_LO_Z);
    is_script = s.match && (s.count == NAME_LEN);
    if (b == CH_TAB || b == CH_LF || b == CH_FF || b == CH_CR || b == CH_SPACE) begin
      term = EV_SPACE;
    end else if (b == CH_SLASH) begin
      term = EV_SLASH;
    end else if (b == CH_GT) begin
      term = EV_GT;
    end else begin
      term = EV_NONE;
    end
    unique case (s.state)
      ST_DATA: begin
        if (b == CH_LT) r.s.state = ST_LT;
      end
      ST_LT: begin
        if (b == CH_SLASH) r.s.state = ST_END_OPEN;
        else if (b == CH_BANG) r.s.state = ST_ESC_START;
        else begin
          r.s.state = ST_DATA;
          r.again   = 1'b1;
        end
      end
      ST_END_OPEN, ST_ESC_END_OPEN: begin
        if (alpha) begin
          r.s.count = 3'd0;
          r.s.match = 1'b1;
          r.s.start = pos;
          r.s.state = (s.state == ST_END_OPEN) ? ST_END_NAME : ST_ESC_END_NAME;
        end else begin
          r.s.state = (s.state == ST_END_OPEN) ? ST_DATA : ST_ESC;
        end
        r.again = 1'b1;
      end
      ST_END_NAME, ST_ESC_END_NAME: begin
        if (term != EV_NONE) begin
          if (is_script) begin
            r.ev      = term;
            r.s.state = ST_ENDED;
          end else begin
            r.s.state = (s.state == ST_END_NAME) ? ST_DATA : ST_ESC;
          end
        end else if (alpha) begin
          r.s = name_add(s, b);
        end else begin
          r.s.state = (s.state == ST_END_NAME) ? ST_DATA : ST_ESC;
          r.again   = 1'b1;
        end
      end
      ST_ESC_START: begin
        if (b == CH_DASH) r.s.state = ST_ESC_START_D;
        else begin
          r.s.state = ST_DATA;
          r.again   = 1'b1;
        end
      end
      ST_ESC_START_D: begin
        if (b == CH_DASH) r.s.state = ST_ESC_DD;
        else begin
          r.s.state = ST_DATA;
          r.again   = 1'b1;
        end
      end
      ST_ESC: begin
        if (b == CH_DASH) r.s.state = ST_ESC_D;
        else if (b == CH_LT) r.s.state = ST_ESC_LT;
      end
      ST_ESC_D: begin
        if (b == CH_DASH) r.s.state = ST_ESC_DD;
        else if (b == CH_LT) r.s.state = ST_ESC_LT;
        else r.s.state = ST_ESC;
      end
      ST_ESC_DD: begin
        if (b == CH_LT) r.s.state = ST_ESC_LT;
        else if (b == CH_GT) r.s.state = ST_DATA;
        else if (b != CH_DASH) r.s.state = ST_ESC;
      end
      ST_ESC_LT: begin
        if (b == CH_SLASH) r.s.state = ST_ESC_END_OPEN;
        else if (alpha) begin
          r.s.count = 3'd0;
          r.s.match = 1'b1;
          r.s.start = pos;
          r.s.state = ST_DBL_START;
          r.again   = 1'b1;
        end else begin
          r.s.state = ST_ESC;
          r.again   = 1'b1;
        end
      end
      ST_DBL_START, ST_DBL_END: begin
        if (term != EV_NONE) begin
          if (is_script) r.s.state = (s.state == ST_DBL_START) ? ST_DBL : ST_ESC;
          else r.s.state = (s.state == ST_DBL_START) ? ST_ESC : ST_DBL;
        end else if (alpha) begin
          r.s = name_add(s, b);
        end else begin
          r.s.state = (s.state == ST_DBL_START) ? ST_ESC : ST_DBL;
          r.again   = 1'b1;
        end
      end
      ST_DBL: begin
        if (b == CH_DASH) r.s.state = ST_DBL_D;
        else if (b == CH_LT) r.s.state = ST_DBL_LT;
      end
      ST_DBL_D: begin
        if (b == CH_DASH) r.s.state = ST_DBL_DD;
        else if (b == CH_LT) r.s.state = ST_DBL_LT;
        else r.s.state = ST_DBL;
      end
      ST_DBL_DD: begin
        if (b == CH_LT) r.s.state = ST_DBL_LT;
        else if (b == CH_GT) r.s.state = ST_DATA;
        else if (b != CH_DASH) r.s.state = ST_DBL;
      end
      ST_DBL_LT: begin
        if (b == CH_SLASH) begin
          r.s.count = 3'd0;
          r.s.match = 1'b1;
          r.s.start = pos;
          r.s.state = ST_DBL_END;
        end else begin
          r.s.state = ST_DBL;
          r.again   = 1'b1;
        end
      end
      ST_ENDED: begin
      end
      default: begin
        r.s.state = ST_DATA;
        r.again   = 1'b1;
      end
    endcase
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    scan_t                    cur;
    pass_t                    r;
    logic                     done;
    logic [POSITION_BITS-1:0] pos;
    if (begin_script) begin
      cur.state = ST_DATA;
      cur.count = 3'd0;
      cur.match = 1'b1;
      cur.start = '0;
      pos       = '0;
    end else begin
      cur = scan;
      pos = byte_position;
    end
    ev_next = EV_NONE;
    done    = 1'b0;
    for (int i = 0; i < PASSES; i++) begin
      if (!done) begin
        r   = scan_pass(cur, data_byte, pos);
        cur = r.s;
        if (r.ev != EV_NONE) ev_next = r.ev;
        done = !r.again;
      end
    end
    scan_next          = cur;
    byte_position_next = pos + {{(POSITION_BITS-1){1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan.state    <= ST_DATA;
      scan.count    <= 3'd0;
      scan.match    <= 1'b1;
      scan.start    <= '0;
      byte_position <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        scan          <= scan_next;
        byte_position <= byte_position_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_res     <= ev_next;
      name_position <= (ev_next != EV_NONE) ? NAME_POS_BITS'(scan_next.start) : '0;
      script_mode   <= mode_of(scan_next.state);
    end
  end

  a_event_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_NONE) |-> script_mode == MODE_ENDED)
    else $error("end tag event without ended mode");

  a_no_event_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_NONE) |-> name_position == '0)
    else $error("name position nonzero without event");

  a_ended_sticks: assert property (@(posedge clk) disable iff (rst)
    in_fire && (scan.state == ST_ENDED) && !begin_script |=> scan.state == ST_ENDED)
    else $error("left ended state without new script");

  a_pos_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && !begin_script |=>
      byte_position == $past(byte_position) + {{(POSITION_BITS-1){1'b0}}, 1'b1})
    else $error("byte position did not advance");

  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(scan.state))
    else $error("scan state not one-hot");

endmodule
